### hdl/bse_pkg.sv
// Shared types, constants and codes of the bitmap sort engine.
package bse_pkg;

  localparam int UNIVERSE_MAX = 1048576;
  localparam int WORD_BITS    = 64;
  localparam int WORD_COUNT   = (UNIVERSE_MAX + WORD_BITS - 1) / WORD_BITS;
  localparam int WADDR_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_W        = $clog2(WORD_BITS);
  localparam int CUR_W        = $clog2(UNIVERSE_MAX);
  localparam int VALUE_W      = 20;
  localparam int CFG_W        = 21;
  localparam int STATUS_W     = 3;
  localparam int IDX_W        = WADDR_W + BIT_W;

  localparam logic [CFG_W-1:0] UNIVERSE_RESET = CFG_W'(1000000);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_RANGE    = 3'd1,
    ST_DUP      = 3'd2,
    ST_EMIT     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_INS,
    S_POP
  } state_t;

  typedef struct packed {
    logic               op;
    logic [VALUE_W-1:0] value_in;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] value_out;
  } result_t;

  typedef struct packed {
    logic                 we;
    logic [WADDR_W-1:0]   waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [WADDR_W-1:0]   raddr;
  } mem_req_t;

endpackage

### hdl/bse_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/bse_find.sv
// Lowest-set-bit finder over one bitmap word.
module bse_find (
  input  logic [bse_pkg::WORD_BITS-1:0] word,
  output logic                          found,
  output logic [bse_pkg::BIT_W-1:0]     bit_idx
);
  import bse_pkg::*;

  always_comb begin
    found   = |word;
    bit_idx = '0;
    // Walking down leaves the lowest set bit as the last one assigned.
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) begin
        bit_idx = BIT_W'(i);
      end
    end
  end

endmodule

### hdl/bse_ctrl.sv
// Sequencer: clearing pass, insert read-modify-write and pop word scan.
module bse_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  bse_pkg::cmd_t                 cmd,
  output logic                          busy,
  output logic                          done,
  output bse_pkg::result_t              result,
  input  logic                          cfg_wen,
  input  logic [bse_pkg::CFG_W-1:0]     cfg_wdata,
  output bse_pkg::mem_req_t             mem,
  input  logic [bse_pkg::WORD_BITS-1:0] rdata
);
  import bse_pkg::*;

  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORD_COUNT - 1);

  state_t               state, state_next;
  logic [CFG_W-1:0]     universe;
  logic [CUR_W-1:0]     cursor, cursor_next;
  logic [VALUE_W-1:0]   val, val_next;
  logic [WADDR_W-1:0]   scan_w, scan_w_next;
  logic                 first, first_next;
  logic [WADDR_W-1:0]   clr_addr, clr_addr_next;
  logic                 done_next;
  result_t              result_next;

  logic [VALUE_W-1:0]   val_word;
  logic [VALUE_W-1:0]   in_word;
  logic [CUR_W-1:0]     cur_word;
  logic [BIT_W-1:0]     val_bit;
  logic [BIT_W-1:0]     cur_bit;
  logic [WORD_BITS-1:0] scan_data;
  logic                 found;
  logic [BIT_W-1:0]     found_bit;
  logic [IDX_W-1:0]     found_idx;
  logic                 over_limit;

  assign in_word   = cmd.value_in >> BIT_W;
  assign val_word  = val >> BIT_W;
  assign cur_word  = cursor >> BIT_W;
  assign val_bit   = val[BIT_W-1:0];
  assign cur_bit   = cursor[BIT_W-1:0];
  assign found_idx = {scan_w, found_bit};

  // Only the first word of a scan drops the bits below the cursor.
  assign scan_data = first ? (rdata & ({WORD_BITS{1'b1}} << cur_bit)) : rdata;

  assign over_limit = (32'(val) >= 32'(universe)) || (32'(val) >= UNIVERSE_MAX);

  bse_find u_find (
    .word    (scan_data),
    .found   (found),
    .bit_idx (found_bit)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      universe <= UNIVERSE_RESET;
      cursor   <= '0;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      cursor   <= cursor_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
      if (cfg_wen) begin
        universe <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    val    <= val_next;
    scan_w <= scan_w_next;
    first  <= first_next;
    result <= result_next;
  end

  always_comb begin
    state_next    = state;
    cursor_next   = cursor;
    val_next      = val;
    scan_w_next   = scan_w;
    first_next    = first;
    clr_addr_next = clr_addr;
    done_next     = 1'b0;
    result_next   = result;
    mem.we        = 1'b0;
    mem.waddr     = '0;
    mem.wdata     = '0;
    mem.raddr     = '0;

    case (state)
      S_CLEAR: begin
        mem.we        = 1'b1;
        mem.waddr     = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          val_next = cmd.value_in;
          if (cmd.op == OP_INSERT) begin
            mem.raddr  = WADDR_W'(in_word);
            state_next = S_INS;
          end else begin
            mem.raddr   = WADDR_W'(cur_word);
            scan_w_next = WADDR_W'(cur_word);
            first_next  = 1'b1;
            state_next  = S_POP;
          end
        end
      end
      S_INS: begin
        done_next             = 1'b1;
        result_next.value_out = '0;
        state_next            = S_IDLE;
        if (over_limit) begin
          result_next.status = ST_RANGE;
        end else if (rdata[val_bit]) begin
          result_next.status = ST_DUP;
        end else begin
          result_next.status = ST_INSERTED;
          mem.we             = 1'b1;
          mem.waddr          = WADDR_W'(val_word);
          mem.wdata          = rdata | (WORD_BITS'(1) << val_bit);
          if (32'(val) < 32'(cursor)) begin
            cursor_next = CUR_W'(val);
          end
        end
      end
      S_POP: begin
        // The next word is read ahead every cycle; it is dropped when the scan ends.
        mem.raddr  = scan_w + 1'b1;
        first_next = 1'b0;
        if (found) begin
          mem.we                = 1'b1;
          mem.waddr             = scan_w;
          mem.wdata             = rdata & ~(WORD_BITS'(1) << found_bit);
          cursor_next           = CUR_W'(found_idx);
          result_next.status    = ST_EMIT;
          result_next.value_out = VALUE_W'(found_idx);
          done_next             = 1'b1;
          state_next            = S_IDLE;
        end else if (scan_w == LAST_WORD) begin
          cursor_next           = '0;
          result_next.status    = ST_EMPTY;
          result_next.value_out = '0;
          done_next             = 1'b1;
          state_next            = S_IDLE;
        end else begin
          scan_w_next = scan_w + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not make the block busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_INS || $past(state) == S_POP))
    else $error("result strobe without a finished insert or pop");

  a_zero_value: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_EMIT) |-> (result.value_out == '0))
    else $error("value_out not zero on a non-emit result");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem.we)
    else $error("memory written while idle");

  a_no_done_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && $past(state) == S_CLEAR) |-> !done)
    else $error("result strobe during the clearing pass");

endmodule

### hdl/bitmap_sort_engine_top.sv
// Top level of the bitmap sort engine: controller and bitmap memory.
//
// Usage: a command beat is taken at a rising edge with start high and busy
// low. cmd.op selects insert (value_in) or pop of the smallest stored value.
// Each command returns exactly one result beat: done is high for one cycle
// with result.status and result.value_out valid. The receiver cannot stall;
// the result must be taken in that cycle.
// An insert is a read-modify-write of one 64-bit bitmap word: busy stays
// high through the S_INS state after acceptance, done follows in the cycle
// after it, and the next command may be accepted in the cycle done is shown.
// A pop scans bitmap words upward from the cursor, one word per cycle
// through the memory read port: it stays busy in S_POP while it inspects
// between 1 and 16384 words, then done follows.
// Reset (synchronous, rst) sets the universe size to 1000000, the cursor to
// zero and starts a clearing pass that writes all 16384 words, one per
// cycle; busy stays high until the pass ends. cfg_wen writes universe_size
// at any edge, and is meant to be used only while the block is idle.
module bitmap_sort_engine_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  bse_pkg::cmd_t             cmd,
  output logic                      busy,
  output logic                      done,
  output bse_pkg::result_t          result,
  input  logic                      cfg_wen,
  input  logic [bse_pkg::CFG_W-1:0] cfg_wdata
);
  import bse_pkg::*;

  mem_req_t             mem;
  logic [WORD_BITS-1:0] rdata;

  bse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .mem       (mem),
    .rdata     (rdata)
  );

  bse_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

endmodule

### tb/bitmap_sort_engine_chk.sv
// Checker for the bitmap sort engine: tracks the bitmap, predicts each result and compares.
module bitmap_sort_engine_chk (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  bse_pkg::cmd_t             cmd,
  input  logic                      done,
  input  bse_pkg::result_t          result,
  input  logic                      cfg_wen,
  input  logic [bse_pkg::CFG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending,
  output int                        stored_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import bse_pkg::*;

  logic [WORD_BITS-1:0] bitmap [WORD_COUNT];
  logic [CUR_W-1:0]     cursor;
  logic [CFG_W-1:0]     universe;
  result_t              sorted_q [$];

  // Applies one command to the shadow bitmap and returns the result it must produce.
  function automatic result_t sort_step(input cmd_t c);
    result_t              r;
    int unsigned          lim;
    int unsigned          w;
    int unsigned          b;
    logic [WORD_BITS-1:0] word;
    r.status    = ST_INSERTED;
    r.value_out = '0;
    lim = (universe < UNIVERSE_MAX) ? universe : UNIVERSE_MAX;
    if (c.op == OP_INSERT) begin
      if (c.value_in >= lim) begin
        r.status = ST_RANGE;
      end else if (bitmap[c.value_in / WORD_BITS][c.value_in % WORD_BITS]) begin
        r.status = ST_DUP;
      end else begin
        bitmap[c.value_in / WORD_BITS][c.value_in % WORD_BITS] = 1'b1;
        stored_count++;
        if (c.value_in < cursor) cursor = c.value_in;
      end
    end else begin
      w = cursor / WORD_BITS;
      // Bits below the cursor in its own word were already emitted.
      word = bitmap[w] & ~((WORD_BITS'(1) << (cursor % WORD_BITS)) - 1'b1);
      while (word == '0 && w < WORD_COUNT - 1) begin
        w++;
        word = bitmap[w];
      end
      if (word == '0) begin
        cursor   = '0;
        r.status = ST_EMPTY;
      end else begin
        b = 0;
        while (!word[b]) b++;
        bitmap[w][b] = 1'b0;
        stored_count--;
        cursor      = CUR_W'(w * WORD_BITS + b);
        r.status    = ST_EMIT;
        r.value_out = VALUE_W'(cursor);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (bitmap[i]) bitmap[i] = '0;
      cursor       = '0;
      universe     = UNIVERSE_RESET;
      stored_count = 0;
      fail_count   = 0;
      sorted_q.delete();
    end else begin
      // The finished beat always belongs to an older command than one taken now.
      if (done) begin
        if (sorted_q.size() == 0) begin
          $error("result beat with no command outstanding: status %0d, value_out %0d",
                 result.status, result.value_out);
          fail_count++;
        end else begin
          want = sorted_q.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            fail_count++;
          end
          if (result.value_out !== want.value_out) begin
            $error("value_out: expected %0d, got %0d", want.value_out, result.value_out);
            fail_count++;
          end
        end
      end
      if (start && !busy) sorted_q.push_back(sort_step(cmd));
      if (cfg_wen) universe = cfg_wdata;
    end
    pending = sorted_q.size();
  end

endmodule

### tb/bitmap_sort_engine_top_tb.sv
// Testbench top for the bitmap sort engine: clock, reset, command stimulus and verdict.
module bitmap_sort_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bse_pkg::*;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  cmd_t             cmd       = '0;
  logic             cfg_wen   = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             busy;
  logic             done;
  result_t          result;
  int               fail_count;
  int               pending;
  int               stored_count;
  int               sender_idle  = 0;
  int               empty_budget = 10;

  always #2 clk = ~clk;

  bitmap_sort_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  bitmap_sort_engine_chk chk (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .done         (done),
    .result       (result),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .stored_count (stored_count)
  );

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // Start is left high so a back-to-back beat needs no extra assignment.
  task automatic send(input logic op, input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= '{op: op, value_in: v};
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic set_universe(input logic [CFG_W-1:0] u);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= u;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] u, input int idle, input int n);
    int unsigned          lim;
    int unsigned          r;
    logic [VALUE_W-1:0]   v;
    set_universe(u);
    sender_idle = idle;
    lim = (u < UNIVERSE_MAX) ? u : UNIVERSE_MAX;
    repeat (n) begin
      if (stored_count > 0 && $urandom_range(99) < 45) begin
        send(OP_POP, VALUE_W'($urandom));
      end else if (stored_count == 0 && empty_budget > 0 && $urandom_range(99) < 3) begin
        // An empty pop scans up to the last word of the store, so they are rationed.
        empty_budget--;
        send(OP_POP, VALUE_W'($urandom));
      end else begin
        r = $urandom_range(99);
        if (r < 8) begin
          v = (lim < UNIVERSE_MAX) ? VALUE_W'($urandom_range(UNIVERSE_MAX - 1, lim))
                                   : VALUE_W'($urandom_range(1023));
        end else if (r < 10 && lim > 8192) begin
          // Rare high values force long scans on the next pops.
          v = VALUE_W'($urandom_range(lim - 1, 0));
        end else if (r < 60) begin
          v = VALUE_W'($urandom_range(((lim < 1024) ? lim : 1024) - 1, 0));
        end else begin
          v = VALUE_W'($urandom_range(((lim < 8192) ? lim : 8192) - 1, 0));
        end
        send(OP_INSERT, v);
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed beats at the reset universe of 1000000.
    send(OP_POP, 20'hFFFFF);
    send(OP_INSERT, 20'd0);
    send(OP_INSERT, 20'hFFFFF);
    send(OP_INSERT, 20'd999999);
    send(OP_INSERT, 20'd1000000);
    send(OP_INSERT, 20'd77);
    send(OP_INSERT, 20'd77);
    send(OP_INSERT, 20'd64);
    send(OP_POP, 20'h55555);
    send(OP_POP, 20'hAAAAA);
    // Inserting below the cursor pulls it back down.
    send(OP_INSERT, 20'd63);
    send(OP_POP, 20'd0);
    send(OP_POP, 20'd0);
    send(OP_POP, 20'd0);
    send(OP_POP, 20'd0);

    set_universe(21'd0);
    send(OP_INSERT, 20'd0);
    send(OP_INSERT, 20'd5);

    // A universe beyond the storage is clipped to it.
    set_universe(21'h1FFFFF);
    send(OP_INSERT, 20'hFFFFF);
    send(OP_POP, 20'd0);
    send(OP_POP, 20'd0);

    set_universe(21'(UNIVERSE_MAX));
    send(OP_INSERT, 20'hFFFFF);
    send(OP_INSERT, 20'd12);

    // Shrinking the universe leaves stored values poppable.
    set_universe(21'd1);
    send(OP_INSERT, 20'd0);
    send(OP_INSERT, 20'd1);
    send(OP_POP, 20'd0);
    send(OP_POP, 20'd0);
    send(OP_POP, 20'd0);
    send(OP_POP, 20'd0);

    random_phase(21'd1000000, 0, 300);
    random_phase(21'd4096, 53, 300);
    random_phase(21'h1FFFFF, 0, 250);
    random_phase(21'(UNIVERSE_MAX), 19, 250);
    random_phase(21'd40, 53, 150);

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (32) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Every beat a full-store pop would still finish well inside this bound.
  initial begin
    #400ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
